>>> rtl/msm_pkg.sv
// ============================================================================
// msm_pkg
// Shared types and constants of the multichannel sample mixer: request and
// result records, controller/datapath command and status, and FSM states.
// ============================================================================
package msm_pkg;

    // number of voices held in the channel file
    localparam int CHANNELS = 16;
    // bits needed to address one voice
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // width used to compare a channel number against the voice count
    localparam int CHK_W    = 6;
    // bits of the playing mask on the result
    localparam int MASK_W   = 16;

    // lump header checks
    localparam logic [31:0] HDR_BYTES  = 32'd8;
    localparam logic [15:0] FMT_VALID  = 16'h0003;
    localparam logic [31:0] MIN_DECL   = 32'd48;
    localparam logic [15:0] LEN_TRIM   = 16'd32;

    // gain arithmetic
    localparam logic [7:0]  PAN_FULL   = 8'd254;
    localparam logic [7:0]  PAN_NEG    = 8'd255;
    localparam logic [9:0]  GAIN_MAX   = 10'd255;
    localparam logic [8:0]  SAMPLE_BIAS = 9'd128;
    // floor(p / 127) == (p * RECIP_127) >> RECIP_SHIFT for p below 2**16
    localparam logic [16:0] RECIP_127  = 17'd66053;
    localparam int          RECIP_SHIFT = 23;

    // request kinds
    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_STOP   = 2'd1,
        KIND_VOLPAN = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

    // one request
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  channel;
        logic [7:0]  volume;
        logic [7:0]  separation;
        logic [7:0]  sample_byte;
        logic        frame_end;
        logic [31:0] lump_length;
        logic [15:0] format_word;
        logic [31:0] declared_length;
    } t_in_item;

    // one result
    typedef struct packed {
        logic               status;
        logic [15:0]        playing_mask;
        logic [15:0]        channel_position;
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
        logic               frame_valid;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prod;
        logic recip;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_div;
    } t_dp_sts;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_PROD   = 2'd1,
        ST_RECIP  = 2'd2,
        ST_COMMIT = 2'd3
    } t_state;

endpackage

>>> rtl/msm_in_if.sv
// ============================================================================
// msm_in_if
// Request channel of the mixer: valid/ready handshake with a request record.
// ============================================================================
interface msm_in_if
    import msm_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/msm_out_if.sv
// ============================================================================
// msm_out_if
// Result channel of the mixer: valid/ready handshake with a result record.
// ============================================================================
interface msm_out_if
    import msm_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/msm_ctrl.sv
// ============================================================================
// msm_ctrl
// Controller of the mixer: steps each request through multiply, divide (start
// and volume/pan only) and commit; owns the request and result handshakes.
// ============================================================================
module msm_ctrl
    import msm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // result slot can take a new result
    assign slot_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PROD;
            end
            ST_PROD: begin
                n_state = i_sts.needs_div ? ST_RECIP : ST_COMMIT;
            end
            ST_RECIP: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
            end
            ST_RECIP: begin
                o_cmd.recip = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/msm_datapath.sv
// ============================================================================
// msm_datapath
// Datapath of the mixer: request register, shared gain/mix multipliers,
// reciprocal divide by 127, per-voice register file, accumulators and the
// result register.
// ============================================================================
module msm_datapath
    import msm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    // request register
    t_in_item r_item;

    // per-voice register file
    logic        r_act [CHANNELS];
    logic [15:0] r_pos [CHANNELS];
    logic [15:0] r_len [CHANNELS];
    logic [7:0]  r_lg  [CHANNELS];
    logic [7:0]  r_rg  [CHANNELS];

    // mix accumulators
    logic [15:0] r_acc_l, r_acc_r;

    // pipeline stages
    logic signed [18:0] r_prod_l, r_prod_r;
    logic               r_hdr_bad;
    logic [9:0]         r_quo_l, r_quo_r;

    t_out_item r_out;

    // decode
    logic [CHK_W-1:0] ch_ext;
    logic [IDX_W-1:0] idx;
    logic             ch_ok;
    logic             is_start, is_volpan, is_sample;

    assign ch_ext    = {2'b00, r_item.channel};
    assign idx       = ch_ext[IDX_W-1:0];
    assign ch_ok     = ch_ext < CHK_W'(CHANNELS);
    assign is_start  = r_item.kind == KIND_START;
    assign is_volpan = r_item.kind == KIND_VOLPAN;
    assign is_sample = r_item.kind == KIND_SAMPLE;

    assign o_sts.needs_div = is_start || is_volpan;

    // current entry of the addressed voice
    logic        cur_act;
    logic [15:0] cur_pos, cur_len;
    logic [7:0]  cur_lg, cur_rg;

    assign cur_act = r_act[idx];
    assign cur_pos = r_pos[idx];
    assign cur_len = r_len[idx];
    assign cur_lg  = r_lg[idx];
    assign cur_rg  = r_rg[idx];

    // shared multiplier operands: sample * gain, or pan factor * volume
    logic signed [8:0] smp;
    logic [7:0]        factor_l;
    logic signed [9:0] mul_a_l, mul_a_r;
    logic signed [8:0] mul_b_l, mul_b_r;

    assign smp      = $signed({1'b0, r_item.sample_byte}) - $signed(SAMPLE_BIAS);
    assign factor_l = (r_item.separation == PAN_NEG) ? 8'd0
                                                     : PAN_FULL - r_item.separation;
    assign mul_a_l  = is_sample ? 10'(smp) : $signed({2'b00, factor_l});
    assign mul_b_l  = is_sample ? $signed({1'b0, cur_lg}) : $signed({1'b0, r_item.volume});
    assign mul_a_r  = is_sample ? 10'(smp) : $signed({2'b00, r_item.separation});
    assign mul_b_r  = is_sample ? $signed({1'b0, cur_rg}) : $signed({1'b0, r_item.volume});

    // lump header check
    logic [31:0] lump_body;
    logic        hdr_bad;

    assign lump_body = r_item.lump_length - HDR_BYTES;
    assign hdr_bad   = (r_item.lump_length < HDR_BYTES)
                    || (r_item.format_word != FMT_VALID)
                    || (r_item.declared_length > lump_body)
                    || (r_item.declared_length <= MIN_DECL);

    // divide by 127 through the reciprocal
    logic [32:0] quo_full_l, quo_full_r;

    assign quo_full_l = r_prod_l[15:0] * RECIP_127;
    assign quo_full_r = r_prod_r[15:0] * RECIP_127;

    // clamp gains
    logic [7:0] gain_l, gain_r;

    assign gain_l = (r_quo_l > GAIN_MAX) ? GAIN_MAX[7:0] : r_quo_l[7:0];
    assign gain_r = (r_quo_r > GAIN_MAX) ? GAIN_MAX[7:0] : r_quo_r[7:0];

    // new entry of the addressed voice and new accumulators
    logic        e_act;
    logic [15:0] e_pos, e_len;
    logic [7:0]  e_lg, e_rg;
    logic [15:0] step_pos;
    logic [15:0] acc_l, acc_r;
    logic        status;
    logic        frame;

    assign step_pos = cur_pos + 16'd1;

    always_comb begin
        e_act  = cur_act;
        e_pos  = cur_pos;
        e_len  = cur_len;
        e_lg   = cur_lg;
        e_rg   = cur_rg;
        acc_l  = r_acc_l;
        acc_r  = r_acc_r;
        status = 1'b0;
        frame  = 1'b0;
        case (r_item.kind)
            KIND_START: begin
                e_act = 1'b0;
                e_pos = '0;
                e_len = '0;
                e_lg  = '0;
                e_rg  = '0;
                if (!ch_ok || r_hdr_bad) begin
                    status = 1'b1;
                end else begin
                    e_act = 1'b1;
                    e_len = r_item.declared_length[15:0] - LEN_TRIM;
                    e_lg  = gain_l;
                    e_rg  = gain_r;
                end
            end
            KIND_STOP: begin
                e_act = 1'b0;
                e_pos = '0;
                e_len = '0;
                e_lg  = '0;
                e_rg  = '0;
            end
            KIND_VOLPAN: begin
                e_lg = gain_l;
                e_rg = gain_r;
            end
            KIND_SAMPLE: begin
                if (ch_ok && cur_act) begin
                    acc_l = r_acc_l + r_prod_l[15:0];
                    acc_r = r_acc_r + r_prod_r[15:0];
                    if (step_pos >= cur_len) begin
                        e_act = 1'b0;
                        e_pos = '0;
                        e_len = '0;
                        e_lg  = '0;
                        e_rg  = '0;
                    end else begin
                        e_pos = step_pos;
                    end
                end
                frame = r_item.frame_end;
            end
            default: begin
                status = 1'b0;
            end
        endcase
    end

    logic wr_entry;
    assign wr_entry = i_cmd.commit && ch_ok;

    // playing mask after this request
    logic [MASK_W-1:0] mask;

    for (genvar c = 0; c < MASK_W; c++) begin : g_mask
        if (c < CHANNELS) begin : g_used
            assign mask[c] = (wr_entry && idx == IDX_W'(c)) ? e_act : r_act[c];
        end else begin : g_unused
            assign mask[c] = 1'b0;
        end
    end

    // request register and arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.prod) begin
            r_prod_l  <= mul_a_l * mul_b_l;
            r_prod_r  <= mul_a_r * mul_b_r;
            r_hdr_bad <= hdr_bad;
        end
        if (i_cmd.recip) begin
            r_quo_l <= quo_full_l[32:RECIP_SHIFT];
            r_quo_r <= quo_full_r[32:RECIP_SHIFT];
        end
    end

    // voice register file and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_act[c] <= 1'b0;
                r_pos[c] <= '0;
                r_len[c] <= '0;
                r_lg[c]  <= '0;
                r_rg[c]  <= '0;
            end
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (i_cmd.commit) begin
            if (ch_ok) begin
                r_act[idx] <= e_act;
                r_pos[idx] <= e_pos;
                r_len[idx] <= e_len;
                r_lg[idx]  <= e_lg;
                r_rg[idx]  <= e_rg;
            end
            r_acc_l <= frame ? 16'd0 : acc_l;
            r_acc_r <= frame ? 16'd0 : acc_r;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.status           <= status;
            r_out.playing_mask     <= mask;
            r_out.channel_position <= ch_ok ? e_pos : 16'd0;
            r_out.mix_left         <= frame ? $signed(acc_l) : 16'sd0;
            r_out.mix_right        <= frame ? $signed(acc_r) : 16'sd0;
            r_out.frame_valid      <= frame;
        end
    end

    assign o_result = r_out;

endmodule

>>> rtl/multichannel_sample_mixer.sv
// ============================================================================
// multichannel_sample_mixer
// A taken request is registered, multiplied, divided by 127 for start and
// volume/pan requests only, then committed to the result register once the
// result slot is free. One request in flight at a time: a new request is
// taken only after the previous one has been committed.
// Synchronous active-low reset clears all voices and both accumulators at once.
// ============================================================================
module multichannel_sample_mixer
    import msm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    msm_in_if.sink   i_in,
    msm_out_if.source o_out
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_out_item result;
    logic      in_ready;
    logic      out_valid;

    // sequencing and handshakes
    msm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // voice state and arithmetic
    msm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_item   (i_in.data),
        .o_result (result)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = result;

endmodule

>>> bench/mixer_checker.sv
// ============================================================================
// mixer_checker
// Watches the request and result channels of the sample mixer. Each taken
// request runs through a cycle-free model of the voices and the stereo sums,
// and each taken result is compared field by field with the oldest prediction.
// ============================================================================
module mixer_checker
    import msm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_ready,
    input  t_in_item  i_req,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_out_item i_res,
    output int        o_mismatches,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // lump header rules and gain arithmetic
    localparam logic [31:0] HEADER_BYTES  = 32'd8;
    localparam logic [15:0] FORMAT_OK     = 16'h0003;
    localparam logic [31:0] MIN_DECLARED  = 32'd48;
    localparam logic [31:0] LENGTH_TRIM   = 32'd32;
    localparam int          PAN_SPAN      = 254;
    localparam int          GAIN_DIV      = 127;
    localparam int          GAIN_CEIL     = 255;
    localparam int          SAMPLE_OFFSET = 128;
    localparam int          MAX_REPORTS   = 10;

    // voice file and stereo sums
    logic        voice_on  [CHANNELS];
    logic [15:0] voice_pos [CHANNELS];
    logic [15:0] voice_len [CHANNELS];
    logic [7:0]  gain_l    [CHANNELS];
    logic [7:0]  gain_r    [CHANNELS];
    logic [15:0] sum_l;
    logic [15:0] sum_r;

    // predicted results, oldest first
    t_out_item   mix_results_due[$];

    function automatic void silence_voice(int c);
        voice_on[c]  = 1'b0;
        voice_pos[c] = '0;
        voice_len[c] = '0;
        gain_l[c]    = '0;
        gain_r[c]    = '0;
    endfunction

    // truncating divide by 127, clamped to a byte
    function automatic logic [7:0] pan_gain(int factor, int vol);
        int g;
        g = (factor * vol) / GAIN_DIV;
        if (g < 0)
            g = 0;
        else if (g > GAIN_CEIL)
            g = GAIN_CEIL;
        return 8'(g);
    endfunction

    function automatic void apply_volpan(int c, logic [7:0] vol, logic [7:0] sep);
        gain_l[c] = pan_gain(PAN_SPAN - int'(sep), int'(vol));
        gain_r[c] = pan_gain(int'(sep), int'(vol));
    endfunction

    // one request in, one result out
    function automatic t_out_item predict_mix(t_in_item req);
        t_out_item res;
        int        c;
        int        term;
        logic [7:0] lg;
        logic [7:0] rg;
        res = '0;
        c   = int'(req.channel);
        case (req.kind)
            KIND_START: begin
                silence_voice(c);
                if (req.lump_length < HEADER_BYTES || req.format_word != FORMAT_OK ||
                    req.declared_length > req.lump_length - HEADER_BYTES ||
                    req.declared_length <= MIN_DECLARED) begin
                    res.status = 1'b1;
                end else begin
                    voice_on[c]  = 1'b1;
                    voice_pos[c] = '0;
                    voice_len[c] = 16'(req.declared_length - LENGTH_TRIM);
                    apply_volpan(c, req.volume, req.separation);
                end
            end
            KIND_STOP: begin
                silence_voice(c);
            end
            KIND_VOLPAN: begin
                apply_volpan(c, req.volume, req.separation);
            end
            default: begin
                // playing voice mixes even on its last sample
                if (voice_on[c]) begin
                    term = int'(req.sample_byte) - SAMPLE_OFFSET;
                    lg   = gain_l[c];
                    rg   = gain_r[c];
                    voice_pos[c] = voice_pos[c] + 16'd1;
                    if (voice_pos[c] >= voice_len[c])
                        silence_voice(c);
                    sum_l = sum_l + 16'(term * int'(lg));
                    sum_r = sum_r + 16'(term * int'(rg));
                end
                if (req.frame_end) begin
                    res.mix_left    = sum_l;
                    res.mix_right   = sum_r;
                    res.frame_valid = 1'b1;
                    sum_l = '0;
                    sum_r = '0;
                end
            end
        endcase
        for (int v = 0; v < CHANNELS && v < 16; v++)
            res.playing_mask[v] = voice_on[v];
        res.channel_position = voice_pos[c];
        return res;
    endfunction

    // start from the reset state
    initial begin
        for (int v = 0; v < CHANNELS; v++)
            silence_voice(v);
        sum_l         = '0;
        sum_r         = '0;
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // predict on each request, compare on each result
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n === 1'b1) begin
            if (i_req_valid === 1'b1 && i_req_ready === 1'b1)
                mix_results_due.push_back(predict_mix(i_req));
            if (i_res_valid === 1'b1 && i_res_ready === 1'b1) begin
                if (mix_results_due.size() == 0) begin
                    if (o_mismatches < MAX_REPORTS)
                        $display("%0t: unexpected result st=%0d mask=%h pos=%h l=%h r=%h fv=%0d",
                                 $realtime, i_res.status, i_res.playing_mask,
                                 i_res.channel_position, i_res.mix_left, i_res.mix_right,
                                 i_res.frame_valid);
                    o_mismatches++;
                end else begin
                    due = mix_results_due.pop_front();
                    if (i_res.status !== due.status ||
                        i_res.playing_mask !== due.playing_mask ||
                        i_res.channel_position !== due.channel_position ||
                        i_res.mix_left !== due.mix_left ||
                        i_res.mix_right !== due.mix_right ||
                        i_res.frame_valid !== due.frame_valid) begin
                        if (o_mismatches < MAX_REPORTS) begin
                            $display("%0t: mismatch exp st=%0d mask=%h pos=%h l=%h r=%h fv=%0d",
                                     $realtime, due.status, due.playing_mask,
                                     due.channel_position, due.mix_left, due.mix_right,
                                     due.frame_valid);
                            $display("%0t:          got st=%0d mask=%h pos=%h l=%h r=%h fv=%0d",
                                     $realtime, i_res.status, i_res.playing_mask,
                                     i_res.channel_position, i_res.mix_left, i_res.mix_right,
                                     i_res.frame_valid);
                        end
                        o_mismatches++;
                    end
                end
            end
            o_outstanding = mix_results_due.size();
        end
    end

endmodule

>>> bench/tb_multichannel_sample_mixer.sv
// ============================================================================
// tb_multichannel_sample_mixer
// Drives start, stop, volume/pan and sample requests into the mixer: a short
// directed run over header checks, pan extremes and voice end, then random
// voice sessions under several sender and receiver idling mixes. Checking is
// done by mixer_checker; this module only makes stimulus and gives the verdict.
// ============================================================================
module tb_multichannel_sample_mixer;
    import msm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] FORMAT_OK    = 16'h0003;
    localparam logic [31:0] HEADER_BYTES = 32'd8;
    localparam logic [31:0] LENGTH_TRIM  = 32'd32;
    localparam int          PHASE_ITEMS  = 325;
    localparam int          SETTLE_CYCLES = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   mismatches;
    int   outstanding;

    msm_in_if  req_bus ();
    msm_out_if res_bus ();

    multichannel_sample_mixer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (res_bus)
    );

    mixer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_bus.valid),
        .i_req_ready   (req_bus.ready),
        .i_req         (req_bus.data),
        .i_res_valid   (res_bus.valid),
        .i_res_ready   (res_bus.ready),
        .i_res         (res_bus.data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side back-pressure
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // hard stop if the mixer hangs
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_request(t_in_item req);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= req;
        do
            @(posedge i_clk);
        while (req_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // hold off until every predicted result has come back
    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    // volume and pan, leaning on the clamp corners
    function automatic logic [7:0] pick_level();
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0:       return 8'd0;
                1:       return 8'd127;
                2:       return 8'd254;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic t_in_item start_request(logic [3:0] ch, logic [7:0] vol,
                                               logic [7:0] sep, logic [31:0] lump,
                                               logic [15:0] fmt, logic [31:0] decl);
        t_in_item req;
        req                 = '0;
        req.kind            = KIND_START;
        req.channel         = ch;
        req.volume          = vol;
        req.separation      = sep;
        req.sample_byte     = 8'hFF;
        req.frame_end       = 1'b1;
        req.lump_length     = lump;
        req.format_word     = fmt;
        req.declared_length = decl;
        return req;
    endfunction

    function automatic t_in_item plain_request(t_kind kind, logic [3:0] ch, logic [7:0] vol,
                                               logic [7:0] sep, logic [7:0] sample,
                                               logic fe);
        t_in_item req;
        req             = '0;
        req.kind        = kind;
        req.channel     = ch;
        req.volume      = vol;
        req.separation  = sep;
        req.sample_byte = sample;
        req.frame_end   = fe;
        return req;
    endfunction

    // mostly playable voice sessions, some broken headers and noise
    function automatic t_in_item random_request();
        t_in_item    req;
        int          roll;
        logic [32:0] span;
        req.kind            = KIND_SAMPLE;
        req.channel         = 4'($urandom_range(15));
        req.volume          = pick_level();
        req.separation      = pick_level();
        req.sample_byte     = 8'($urandom_range(255));
        req.frame_end       = ($urandom_range(3) == 0);
        req.lump_length     = $urandom();
        req.format_word     = 16'($urandom());
        req.declared_length = $urandom();
        roll = $urandom_range(99);
        if (roll < 15) begin
            req.kind = KIND_START;
            if ($urandom_range(3) != 0) begin
                // valid header: short voices, length wrap, or long ones
                req.format_word = FORMAT_OK;
                case ($urandom_range(9))
                    0, 1: req.declared_length = 32'($urandom_range(1, 65534)) * 32'd65536 +
                                                LENGTH_TRIM + 32'($urandom_range(0, 40));
                    2:    req.declared_length = 32'($urandom_range(49, 1 << 20));
                    default: req.declared_length = 32'($urandom_range(49, 96));
                endcase
                span = {1'b0, req.declared_length} + {1'b0, HEADER_BYTES} +
                       33'($urandom_range(0, 40));
                req.lump_length = span[32] ? '1 : span[31:0];
            end else begin
                // broken header
                case ($urandom_range(4))
                    0: req.lump_length = 32'($urandom_range(0, 7));
                    1: begin
                        req.lump_length     = 32'd100;
                        req.declared_length = 32'd49;
                        if (req.format_word == FORMAT_OK)
                            req.format_word = 16'h0300;
                    end
                    2: begin
                        req.lump_length     = 32'd100;
                        req.format_word     = FORMAT_OK;
                        req.declared_length = 32'($urandom_range(0, 48));
                    end
                    3: begin
                        req.lump_length     = 32'($urandom_range(57, 1000));
                        req.format_word     = FORMAT_OK;
                        req.declared_length = req.lump_length - 32'($urandom_range(0, 7));
                    end
                    default: ;
                endcase
            end
        end else if (roll < 20) begin
            req.kind = KIND_STOP;
        end else if (roll < 30) begin
            req.kind = KIND_VOLPAN;
        end
        return req;
    endfunction

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: header checks, pan corners, voice end, idle voice, ignored frame end
        send_request(start_request(4'd0, 8'd255, 8'd0, 32'd100, FORMAT_OK, 32'd49));
        send_request(start_request(4'd5, 8'd100, 8'd10, 32'd7, FORMAT_OK, 32'd0));
        send_request(start_request(4'd5, 8'd100, 8'd10, 32'd100, 16'hFFFF, 32'd49));
        send_request(start_request(4'd5, 8'd100, 8'd10, 32'd56, FORMAT_OK, 32'd49));
        send_request(start_request(4'd5, 8'd100, 8'd10, 32'd56, FORMAT_OK, 32'd48));
        send_request(start_request(4'd1, 8'd127, 8'd127, 32'd57, FORMAT_OK, 32'd49));
        send_request(start_request(4'd2, 8'd255, 8'd255, 32'hFFFF_FFFF, FORMAT_OK, 32'd65568));
        send_request(plain_request(KIND_SAMPLE, 4'd2, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(plain_request(KIND_SAMPLE, 4'd0, 8'd0, 8'd0, 8'd255, 1'b1));
        send_request(plain_request(KIND_VOLPAN, 4'd3, 8'd0, 8'd254, 8'd0, 1'b1));
        send_request(plain_request(KIND_SAMPLE, 4'd3, 8'd0, 8'd0, 8'd200, 1'b1));
        send_request(plain_request(KIND_STOP, 4'd0, 8'd255, 8'd255, 8'd255, 1'b1));
        send_request(plain_request(KIND_VOLPAN, 4'd1, 8'd255, 8'd128, 8'd0, 1'b0));
        send_request(plain_request(KIND_SAMPLE, 4'd1, 8'd0, 8'd0, 8'd128, 1'b0));
        send_request(plain_request(KIND_SAMPLE, 4'd1, 8'd0, 8'd0, 8'd1, 1'b1));
        send_request(start_request(4'd15, 8'd0, 8'd0, 32'hFFFF_FFFF, FORMAT_OK,
                                   32'hFFFF_FFF7));
        send_request(start_request(4'd14, 8'd200, 8'd254, 32'hFFFF_FFFF, FORMAT_OK,
                                   32'hFFFF_FFF8));
        send_request(start_request(4'd4, 8'd90, 8'd60, 32'd100, 16'h0300, 32'd60));
        send_request(plain_request(KIND_SAMPLE, 4'd15, 8'd0, 8'd0, 8'h80, 1'b1));
        send_request(plain_request(KIND_VOLPAN, 4'd15, 8'd255, 8'd254, 8'd0, 1'b0));
        send_request(plain_request(KIND_SAMPLE, 4'd15, 8'd0, 8'd0, 8'h7F, 1'b1));
        send_request(plain_request(KIND_SAMPLE, 4'd1, 8'd0, 8'd0, 8'd0, 1'b1));
        wait_for_results();

        // random sessions: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(random_request());
                if (n == PHASE_ITEMS / 2 && phase == 2)
                    wait_for_results();
            end
            wait_for_results();
        end

        // let any stray result show up
        receiver_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> multichannel_sample_mixer.f
rtl/msm_pkg.sv
rtl/msm_in_if.sv
rtl/msm_out_if.sv
rtl/msm_ctrl.sv
rtl/msm_datapath.sv
rtl/multichannel_sample_mixer.sv
bench/mixer_checker.sv
bench/tb_multichannel_sample_mixer.sv
